FILE: hw/rtl/hre_pkg.sv
package hre_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] remaining_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       record_end;
    logic [7:0] record_length;
  } out_item_t;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] TYPE_SEED  = 8'd6;

  typedef logic [3:0] pos_t;

  localparam pos_t POS_COLON  = 4'd0;
  localparam pos_t POS_LEN_HI = 4'd1;
  localparam pos_t POS_LEN_LO = 4'd2;
  localparam pos_t POS_ADDR0  = 4'd3;
  localparam pos_t POS_ADDR1  = 4'd4;
  localparam pos_t POS_ADDR2  = 4'd5;
  localparam pos_t POS_ADDR3  = 4'd6;
  localparam pos_t POS_TYPE_HI = 4'd7;
  localparam pos_t POS_TYPE_LO = 4'd8;
  localparam pos_t POS_DAT_HI = 4'd9;
  localparam pos_t POS_DAT_LO = 4'd10;
  localparam pos_t POS_CS_HI  = 4'd11;
  localparam pos_t POS_CS_LO  = 4'd12;
  localparam pos_t POS_CR     = 4'd13;
  localparam pos_t POS_LF     = 4'd14;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/hex_record_encoder_top.sv
// Intel-HEX style record encoder (type 06, address 0000).
// Input channel item_valid/item_ready carries one transaction per payload
// byte; remaining_length is sampled only when no record is open and clamped
// to MAX_RECORD_BYTES. Output channel result_valid/result_ready carries one
// ASCII character per transaction.
// A transaction opening a record yields ':', length, "0000", "06" (9 chars)
// and, unless the length is zero, its two data characters. Every byte after
// that yields two characters. The byte closing the record (or an empty
// record) adds checksum, CR and LF. last_of_run marks the final character of
// each input transaction, record_end the closing LF.
// The first character passes through the run register and then the output
// register. Throughput is set by the single character output port: one
// character per cycle while the receiver does not stall.
// The next input transaction is accepted in the cycle its predecessor's last
// character moves into the output register, so no bubbles occur.
// Reset clears the record state and empties both pipeline registers. When
// the receiver stalls, the output register holds and the input side stalls
// once the one-transaction run register is full.
module hex_record_encoder_top #(
  parameter int MAX_RECORD_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  hre_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output hre_pkg::out_item_t result
);

  localparam logic [15:0] MAX_LEN16 = 16'(MAX_RECORD_BYTES);
  localparam logic [7:0]  MAX_LEN8  = 8'(MAX_RECORD_BYTES);

  logic       in_record;
  logic [7:0] bytes_left;
  logic [7:0] running_sum;
  logic [7:0] held_length;

  logic          run_valid;
  hre_pkg::pos_t pos;
  hre_pkg::pos_t end_pos;
  logic          has_data;
  logic [7:0]    run_length;
  logic [7:0]    run_data;
  logic [7:0]    run_cs;

  logic accept;
  logic out_load;
  logic run_done;

  logic          in_record_next;
  logic [7:0]    bytes_left_next;
  logic [7:0]    running_sum_next;
  logic [7:0]    held_length_next;
  hre_pkg::pos_t start_pos_next;
  hre_pkg::pos_t end_pos_next;
  logic          has_data_next;

  logic [7:0] clamp_len;
  logic [7:0] sum_base;
  logic [7:0] left_base;

  logic [7:0]    cur_char;
  hre_pkg::pos_t pos_adv;

  assign out_load   = !result_valid || result_ready;
  assign run_done   = run_valid && out_load && (pos == end_pos);
  assign item_ready = !run_valid || run_done;
  assign accept     = item_valid && item_ready;

  always_comb begin
    clamp_len = (item.remaining_length < MAX_LEN16) ? item.remaining_length[7:0] : MAX_LEN8;
    if (!in_record) begin
      held_length_next = clamp_len;
      sum_base         = clamp_len + hre_pkg::TYPE_SEED;
      left_base        = clamp_len;
      start_pos_next   = hre_pkg::POS_COLON;
    end else begin
      held_length_next = held_length;
      sum_base         = running_sum;
      left_base        = bytes_left;
      start_pos_next   = hre_pkg::POS_DAT_HI;
    end
    if (left_base == 8'd0) begin
      has_data_next    = 1'b0;
      running_sum_next = sum_base;
      bytes_left_next  = 8'd0;
    end else begin
      has_data_next    = 1'b1;
      running_sum_next = sum_base + item.data_byte;
      bytes_left_next  = left_base - 8'd1;
    end
    in_record_next = (bytes_left_next != 8'd0);
    end_pos_next   = in_record_next ? hre_pkg::POS_DAT_LO : hre_pkg::POS_LF;
  end

  always_comb begin
    unique case (pos)
      hre_pkg::POS_COLON:   cur_char = hre_pkg::CHAR_COLON;
      hre_pkg::POS_LEN_HI:  cur_char = hre_pkg::hex_char(run_length[7:4]);
      hre_pkg::POS_LEN_LO:  cur_char = hre_pkg::hex_char(run_length[3:0]);
      hre_pkg::POS_ADDR0,
      hre_pkg::POS_ADDR1,
      hre_pkg::POS_ADDR2,
      hre_pkg::POS_ADDR3,
      hre_pkg::POS_TYPE_HI: cur_char = hre_pkg::CHAR_ZERO;
      hre_pkg::POS_TYPE_LO: cur_char = hre_pkg::CHAR_SIX;
      hre_pkg::POS_DAT_HI:  cur_char = hre_pkg::hex_char(run_data[7:4]);
      hre_pkg::POS_DAT_LO:  cur_char = hre_pkg::hex_char(run_data[3:0]);
      hre_pkg::POS_CS_HI:   cur_char = hre_pkg::hex_char(run_cs[7:4]);
      hre_pkg::POS_CS_LO:   cur_char = hre_pkg::hex_char(run_cs[3:0]);
      hre_pkg::POS_CR:      cur_char = hre_pkg::CHAR_CR;
      default:              cur_char = hre_pkg::CHAR_LF;
    endcase
    if (pos == hre_pkg::POS_TYPE_LO && !has_data) begin
      pos_adv = hre_pkg::POS_CS_HI;
    end else begin
      pos_adv = pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_record    <= 1'b0;
      bytes_left   <= 8'd0;
      running_sum  <= 8'd0;
      held_length  <= 8'd0;
      run_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        in_record   <= in_record_next;
        bytes_left  <= bytes_left_next;
        running_sum <= running_sum_next;
        held_length <= held_length_next;
        run_valid   <= 1'b1;
      end else if (run_done) begin
        run_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= run_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos        <= start_pos_next;
      end_pos    <= end_pos_next;
      has_data   <= has_data_next;
      run_length <= held_length_next;
      run_data   <= item.data_byte;
      run_cs     <= 8'd0 - running_sum_next;
    end else if (run_valid && out_load && (pos != end_pos)) begin
      pos <= pos_adv;
    end
    if (out_load && run_valid) begin
      result.out_char      <= cur_char;
      result.last_of_run   <= (pos == end_pos);
      result.record_end    <= (pos == hre_pkg::POS_LF);
      result.record_length <= run_length;
    end
  end

endmodule

FILE: test/tb_hex_record_encoder_top.sv
`timescale 1ns / 100ps

module tb_hex_record_encoder_top;

  localparam int MAX_REC = 16;
  localparam logic [7:0] CHAR_A = 8'h41;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  hre_pkg::in_item_t  item;
  logic               result_valid;
  logic               result_ready;
  hre_pkg::out_item_t result;

  hre_pkg::out_item_t char_queue[$];

  logic       rec_open;
  logic [7:0] rec_left;
  logic [7:0] rec_sum;
  logic [7:0] rec_len;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_req = 0;

  int error_count = 0;
  int bytes_sent = 0;
  int records_opened = 0;
  int chars_checked = 0;

  hex_record_encoder_top #(
    .MAX_RECORD_BYTES(MAX_REC)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
    if (v < 4'd10) begin
      return hre_pkg::CHAR_ZERO + {4'h0, v};
    end
    return CHAR_A + {4'h0, v} - 8'd10;
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic end_flag);
    hre_pkg::out_item_t e;
    e.out_char = c;
    e.last_of_run = 1'b0;
    e.record_end = end_flag;
    e.record_length = rec_len;
    char_queue.push_back(e);
  endfunction

  function automatic void push_hex(input logic [7:0] v);
    push_char(nibble_ascii(v[7:4]), 1'b0);
    push_char(nibble_ascii(v[3:0]), 1'b0);
  endfunction

  function automatic void push_trailer();
    push_hex(8'h00 - rec_sum);
    push_char(hre_pkg::CHAR_CR, 1'b0);
    push_char(hre_pkg::CHAR_LF, 1'b1);
    rec_open = 1'b0;
    rec_left = 8'd0;
  endfunction

  // expected characters for one accepted byte transaction
  function automatic void encode_item(input hre_pkg::in_item_t it);
    int clamp;
    clamp = (int'(it.remaining_length) < MAX_REC) ? int'(it.remaining_length) : MAX_REC;
    if (!rec_open) begin
      rec_len = 8'(clamp);
      records_opened++;
      push_char(hre_pkg::CHAR_COLON, 1'b0);
      push_hex(rec_len);
      repeat (5) push_char(hre_pkg::CHAR_ZERO, 1'b0);
      push_char(hre_pkg::CHAR_SIX, 1'b0);
      rec_sum = rec_len + hre_pkg::TYPE_SEED;
      rec_left = rec_len;
      rec_open = 1'b1;
      if (rec_left == 8'd0) begin
        push_trailer();
        char_queue[char_queue.size() - 1].last_of_run = 1'b1;
        return;
      end
    end
    push_hex(it.data_byte);
    rec_sum = rec_sum + it.data_byte;
    rec_left = rec_left - 8'd1;
    if (rec_left == 8'd0) begin
      push_trailer();
    end
    char_queue[char_queue.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %02h want %02h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin : check_chars
    hre_pkg::out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (char_queue.size() == 0) begin
        report_mismatch("character with none pending", result.out_char, 8'h00);
      end else begin
        want = char_queue.pop_front();
        chars_checked++;
        if (result.out_char !== want.out_char)
          report_mismatch("out_char", result.out_char, want.out_char);
        if (result.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 8'(result.last_of_run), 8'(want.last_of_run));
        if (result.record_end !== want.record_end)
          report_mismatch("record_end", 8'(result.record_end), 8'(want.record_end));
        if (result.record_length !== want.record_length)
          report_mismatch("record_length", result.record_length, want.record_length);
      end
    end
  end

  // receiver: random stalls, optional long hold-off
  initial begin : receiver
    int stall;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        result_ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end
      stall = rx_steady ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid && hold_req == 0);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic [15:0] remain);
    int gap;
    hre_pkg::in_item_t it;
    gap = tx_steady ? 0 : $urandom_range(0, 18);
    it.data_byte = data;
    it.remaining_length = remain;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    encode_item(it);
    bytes_sent++;
  endtask

  task automatic wait_for_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (char_queue.size() != 0) @(posedge clk);
  endtask

  // one well-formed record with random content; some length fields are noise
  task automatic send_record(output int count);
    logic [15:0] remain;
    case ($urandom_range(0, 9))
      0, 1: remain = 16'd0;
      2, 3, 4, 5, 6: remain = 16'($urandom_range(1, MAX_REC));
      7: remain = 16'($urandom_range(MAX_REC + 1, 255));
      default: remain = 16'($urandom_range(0, 65535));
    endcase
    send_byte(8'($urandom_range(0, 255)), remain);
    count = 1;
    while (rec_open) begin
      if ($urandom_range(0, 9) < 7) begin
        remain = {8'h00, rec_left};
      end else begin
        remain = 16'($urandom_range(0, 65535));
      end
      send_byte(8'($urandom_range(0, 255)), remain);
      count++;
    end
  endtask

  task automatic test_record_edges();
    send_byte(8'hFF, 16'h0000);
    send_byte(8'h5A, 16'h0000);
    send_byte(8'h00, 16'd1);
    send_byte(8'hFF, 16'd2);
    send_byte(8'h80, 16'hFFFF);
    send_byte(8'h01, 16'hFFFF);
    for (int i = 0; i < MAX_REC - 1; i++) begin
      send_byte((i % 2 == 0) ? 8'hFF : 8'h00, 16'h8000 >> i);
    end
    wait_for_drain();
  endtask

  task automatic test_random_records();
    int n;
    int total;
    total = 0;
    while (total < 45) begin
      send_record(n);
      total += n;
      if ($urandom_range(0, 7) == 0) begin
        wait_for_drain();
      end
    end
    wait_for_drain();
  endtask

  task automatic test_receiver_holdoff();
    tx_steady = 1'b1;
    hold_req = 300;
    send_byte(8'hC3, 16'd40);
    for (int i = 1; i < MAX_REC; i++) begin
      send_byte(8'($urandom_range(0, 255)), 16'(MAX_REC - i));
    end
    tx_steady = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_steady_stream();
    int n;
    int total;
    total = 0;
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    while (total < 15) begin
      send_record(n);
      total += n;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_for_drain();
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    rec_open = 1'b0;
    rec_left = 8'd0;
    rec_sum = 8'd0;
    rec_len = 8'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_record_edges();
    test_random_records();
    test_receiver_holdoff();
    test_steady_stream();

    repeat (10) @(posedge clk);
    if (char_queue.size() != 0) begin
      report_mismatch("characters never produced", 8'(char_queue.size()), 8'h00);
    end
    $display("Sent %0d byte transactions over %0d records; checked %0d characters.",
             bytes_sent, records_opened, chars_checked);
    $display("Covered empty, clamped and single-byte records, long hold-off, steady flow.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
